// ----- rtl/pwscs_pkg.sv -----
// Shared constants for the pulse-width serial command sender.
package pwscs_pkg;

    // Width of every configuration register and of the configuration data port.
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_READY_TICKS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_TICKS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_TICKS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_TICKS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER_TICKS = 3'd4;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_READY_TICKS     = 16'd3000;
    localparam logic [CFG_W-1:0] RST_SYNC_TICKS      = 16'd2400;
    localparam logic [CFG_W-1:0] RST_ONE_TICKS       = 16'd1200;
    localparam logic [CFG_W-1:0] RST_ZERO_TICKS      = 16'd600;
    localparam logic [CFG_W-1:0] RST_DELIMITER_TICKS = 16'd600;

    // Input word function codes.
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // Bits of a byte are sent from this position down to zero.
    localparam logic [2:0] TOP_BIT = 3'd7;

    // Command frames carry at least this many and at most this many bytes.
    localparam int MIN_FRAME_BYTES = 2;
    localparam int MAX_FRAME_BYTES = 4;

endpackage

// ----- rtl/pulse_width_serial_command_sender.sv -----
// Pulse-width serial command sender: frame sequencer with registered result word.
//
// Usage. The input channel (i_in_valid / o_in_stall) carries one word per tick of
// the line's time base or one command load. A load word (func = 1) stores up to four
// bytes and a byte count and starts a frame, but only while the sender is idle; a load
// that arrives during a frame is dropped and its result word flags command_rejected.
// Each tick word (func = 0) advances the frame by one time unit: a released ready wait,
// a low sync mark, a high delimiter, then every bit MSB first as a low mark (one or zero
// length) followed by a high delimiter. The result channel (o_out_valid / i_out_stall)
// returns exactly one word per input word, giving the line state after that word.
// A word accepted at an edge has its result registered at that edge. Throughput is
// one word per cycle while o_in_stall is low; the frame state update is a short
// decrement and compare on the phase timer. The single result register is refilled in
// the cycle it is taken, so o_in_stall rises only when the result register is full and
// the receiver stalls. Reset (synchronous, active low) returns the sequencer to idle,
// empties the result register and restores the default pulse lengths. Configuration
// writes are taken at any edge with i_cfg_we high and act on the next timer load.
module pulse_width_serial_command_sender
    import pwscs_pkg::*;
#(
    parameter int MAX_BYTES   = 4,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,

    // Input words.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_func,
    input  logic [7:0]           i_first_byte,
    input  logic [7:0]           i_second_byte,
    input  logic [7:0]           i_third_byte,
    input  logic [7:0]           i_fourth_byte,
    input  logic [2:0]           i_byte_count,

    // Result words.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_line_drive_enable,
    output logic                 o_line_level,
    output logic                 o_busy_res,
    output logic                 o_frame_done,
    output logic                 o_command_rejected
);

    // Frames never carry more than four bytes, and never more than the store holds.
    localparam int LOAD_LIMIT = (MAX_BYTES < MAX_FRAME_BYTES) ? MAX_BYTES : MAX_FRAME_BYTES;
    localparam int STORE_N    = LOAD_LIMIT;
    localparam int FW         = $clog2(LOAD_LIMIT + 1);
    localparam int BI         = $clog2(MAX_BYTES);
    localparam int TW         = TIMER_WIDTH;
    localparam logic [TW-1:0] TIMER_MAX = '1;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_READY      = 3'd1,
        PH_SYNC_MARK  = 3'd2,
        PH_SYNC_DELIM = 3'd3,
        PH_BIT_MARK   = 3'd4,
        PH_BIT_DELIM  = 3'd5
    } t_phase;

    // A zero length still lasts one tick; a length beyond the timer saturates.
    function automatic logic [TW-1:0] timer_load(input logic [CFG_W-1:0] v);
        logic [TW-1:0] res;
        if (v == '0) begin
            res = TW'(1);
        end else if (32'(v) > 32'(TIMER_MAX)) begin
            res = TIMER_MAX;
        end else begin
            res = TW'(v);
        end
        return res;
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] r_ready_ticks;
    logic [CFG_W-1:0] r_sync_ticks;
    logic [CFG_W-1:0] r_one_ticks;
    logic [CFG_W-1:0] r_zero_ticks;
    logic [CFG_W-1:0] r_delim_ticks;

    // Frame state.
    t_phase          r_phase,     n_phase;
    logic [TW-1:0]   r_timer,     n_timer;
    logic [FW-1:0]   r_byte_pos,  n_byte_pos;
    logic [2:0]      r_bit_pos,   n_bit_pos;
    logic [FW-1:0]   r_frame_len, n_frame_len;
    logic [7:0]      r_bytes [MAX_BYTES];

    // Result register.
    logic r_out_valid;
    logic r_drive, r_level, r_busy, r_done, r_rejected;

    logic          in_acc;
    logic          load_ok;
    logic          done;
    logic          rejected;
    logic [TW-1:0] timer_dec;
    logic [FW-1:0] adv_byte_pos;
    logic [2:0]    adv_bit_pos;
    logic [FW-1:0] sel_byte_pos;
    logic [2:0]    sel_bit_pos;
    logic [7:0]    sel_byte;
    logic [TW-1:0] mark_len;
    logic [7:0]    load_src [MAX_FRAME_BYTES];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign load_src[0] = i_first_byte;
    assign load_src[1] = i_second_byte;
    assign load_src[2] = i_third_byte;
    assign load_src[3] = i_fourth_byte;

    // Position after the current bit's delimiter ends.
    assign adv_byte_pos = (r_bit_pos == '0) ? r_byte_pos + FW'(1) : r_byte_pos;
    assign adv_bit_pos  = (r_bit_pos == '0) ? TOP_BIT : r_bit_pos - 3'd1;

    // The next mark length is taken from the bit that the next mark sends.
    assign sel_byte_pos = (r_phase == PH_BIT_DELIM) ? adv_byte_pos : r_byte_pos;
    assign sel_bit_pos  = (r_phase == PH_BIT_DELIM) ? adv_bit_pos  : r_bit_pos;
    assign sel_byte     = r_bytes[BI'(sel_byte_pos)];
    assign mark_len     = timer_load(sel_byte[sel_bit_pos] ? r_one_ticks : r_zero_ticks);

    assign timer_dec = r_timer - TW'(r_timer != '0);

    always_comb begin
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_byte_pos  = r_byte_pos;
        n_bit_pos   = r_bit_pos;
        n_frame_len = r_frame_len;
        load_ok     = 1'b0;
        done        = 1'b0;
        rejected    = 1'b0;
        if (in_acc) begin
            if (i_func == FUNC_LOAD) begin
                if (r_phase != PH_IDLE) begin
                    rejected = 1'b1;
                end else begin
                    load_ok    = 1'b1;
                    n_phase    = PH_READY;
                    n_timer    = timer_load(r_ready_ticks);
                    n_byte_pos = '0;
                    n_bit_pos  = TOP_BIT;
                    if (i_byte_count < 3'(MIN_FRAME_BYTES)) begin
                        n_frame_len = FW'(MIN_FRAME_BYTES);
                    end else if (i_byte_count > 3'(LOAD_LIMIT)) begin
                        n_frame_len = FW'(LOAD_LIMIT);
                    end else begin
                        n_frame_len = FW'(i_byte_count);
                    end
                end
            end else if (r_phase != PH_IDLE) begin
                n_timer = timer_dec;
                if (timer_dec == '0) begin
                    case (r_phase)
                        PH_READY: begin
                            n_phase = PH_SYNC_MARK;
                            n_timer = timer_load(r_sync_ticks);
                        end
                        PH_SYNC_MARK: begin
                            n_phase = PH_SYNC_DELIM;
                            n_timer = timer_load(r_delim_ticks);
                        end
                        PH_SYNC_DELIM: begin
                            n_phase = PH_BIT_MARK;
                            n_timer = mark_len;
                        end
                        PH_BIT_MARK: begin
                            n_phase = PH_BIT_DELIM;
                            n_timer = timer_load(r_delim_ticks);
                        end
                        PH_BIT_DELIM: begin
                            if (adv_byte_pos >= r_frame_len) begin
                                n_phase    = PH_IDLE;
                                n_timer    = '0;
                                n_byte_pos = '0;
                                n_bit_pos  = TOP_BIT;
                                done       = 1'b1;
                            end else begin
                                n_phase    = PH_BIT_MARK;
                                n_timer    = mark_len;
                                n_byte_pos = adv_byte_pos;
                                n_bit_pos  = adv_bit_pos;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_timer = '0;
                        end
                    endcase
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_ticks <= RST_READY_TICKS;
            r_sync_ticks  <= RST_SYNC_TICKS;
            r_one_ticks   <= RST_ONE_TICKS;
            r_zero_ticks  <= RST_ZERO_TICKS;
            r_delim_ticks <= RST_DELIMITER_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_READY_TICKS:     r_ready_ticks <= i_cfg_data;
                REG_SYNC_TICKS:      r_sync_ticks  <= i_cfg_data;
                REG_ONE_TICKS:       r_one_ticks   <= i_cfg_data;
                REG_ZERO_TICKS:      r_zero_ticks  <= i_cfg_data;
                REG_DELIMITER_TICKS: r_delim_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Byte store; every entry up to the largest frame is written on every accepted load.
    for (genvar g = 0; g < MAX_BYTES; g++) begin : g_bytes
        if (g < STORE_N) begin : g_wr
            always_ff @(posedge i_clk) begin
                if (load_ok) begin
                    r_bytes[g] <= load_src[g];
                end
            end
        end else begin : g_unused
            // Entries past the largest frame are never written or read.
            always_ff @(posedge i_clk) begin
                r_bytes[g] <= r_bytes[g];
            end
        end
    end

    // Frame sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_byte_pos  <= '0;
            r_bit_pos   <= TOP_BIT;
            r_frame_len <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_timer     <= n_timer;
            r_byte_pos  <= n_byte_pos;
            r_bit_pos   <= n_bit_pos;
            r_frame_len <= n_frame_len;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_acc) begin
            r_drive    <= (n_phase != PH_IDLE) && (n_phase != PH_READY);
            r_level    <= !((n_phase == PH_SYNC_MARK) || (n_phase == PH_BIT_MARK));
            r_busy     <= (n_phase != PH_IDLE);
            r_done     <= done;
            r_rejected <= rejected;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_line_drive_enable = r_drive;
    assign o_line_level        = r_level;
    assign o_busy_res          = r_busy;
    assign o_frame_done        = r_done;
    assign o_command_rejected  = r_rejected;

    // The timer is zero exactly when no frame is running.
    a_idle_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) == (r_timer == '0))
        else $error("phase timer out of step with phase");

    // A frame that ends reports itself as no longer busy and not driving.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> (!r_busy && !r_drive && !r_rejected))
        else $error("frame_done with frame still running");

    // A rejected load leaves the running frame untouched.
    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_func == FUNC_LOAD && r_phase != PH_IDLE)
            |=> (r_phase == $past(r_phase) && r_frame_len == $past(r_frame_len)))
        else $error("rejected load changed frame state");

    // The byte position never passes the end of the frame.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_byte_pos < r_frame_len))
        else $error("byte position beyond frame length");

endmodule

// ----- bench/pulse_width_serial_command_sender_tb.sv -----
// Self-checking testbench for the pulse-width serial command sender frame sequencer.
module pulse_width_serial_command_sender_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pwscs_pkg::*;

    // A typical run needs about 0.15 ms; even the longest random frames under the
    // longest gaps and stalls stay below 1 ms.
    localparam int RUN_LIMIT_NS = 6_000_000;
    // Counted words per random configuration phase.
    localparam int PHASE_WORDS = 80;

    // Sequencer states of the local line model. The block keeps its own encoding,
    // so these never leave the testbench.
    typedef enum logic [2:0] {
        LS_IDLE,
        LS_READY,
        LS_SYNC_MARK,
        LS_SYNC_GAP,
        LS_BIT_MARK,
        LS_BIT_GAP
    } t_line_state;

    // One input word plus the number of idle cycles the sender waits before it.
    typedef struct packed {
        logic       func;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] d3;
        logic [2:0] count;
        logic [3:0] gap;
    } t_cmd_word;

    // Line state that one result word reports.
    typedef struct packed {
        logic drive;
        logic level;
        logic busy;
        logic done;
        logic rejected;
    } t_line_sample;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_READY_TICKS;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic             i_func = FUNC_TICK;
    logic [7:0]       i_first_byte = '0;
    logic [7:0]       i_second_byte = '0;
    logic [7:0]       i_third_byte = '0;
    logic [7:0]       i_fourth_byte = '0;
    logic [2:0]       i_byte_count = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic             o_line_drive_enable;
    logic             o_line_level;
    logic             o_busy_res;
    logic             o_frame_done;
    logic             o_command_rejected;

    pulse_width_serial_command_sender u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Words waiting to be sent, and line states waiting to be seen.
    t_cmd_word    cmd_q[$];
    t_line_sample line_expect_q[$];
    int           mismatches = 0;
    int           words_made = 0;

    // Copy of the pulse-length registers, updated whenever the bench writes one.
    logic [15:0] cfg_ready = RST_READY_TICKS;
    logic [15:0] cfg_sync  = RST_SYNC_TICKS;
    logic [15:0] cfg_one   = RST_ONE_TICKS;
    logic [15:0] cfg_zero  = RST_ZERO_TICKS;
    logic [15:0] cfg_delim = RST_DELIMITER_TICKS;

    // Line model state, starting from the reset values.
    t_line_state ln_state = LS_IDLE;
    logic [15:0] ln_timer = '0;
    logic [7:0]  ln_bytes [4];
    logic [2:0]  ln_byte = '0;
    logic [2:0]  ln_bit = TOP_BIT;
    logic [2:0]  ln_len = '0;

    // Idling controls. quick_run turns all gaps and stalls off for some directed frames;
    // the lazy flags flip now and then so that busy and quiet stretches alternate.
    logic quick_run = 1'b0;
    logic tx_lazy = 1'b1;
    logic rx_lazy = 1'b1;

    // A register value of zero still lasts one tick.
    function automatic logic [15:0] span(input logic [15:0] r);
        return (r == 16'd0) ? 16'd1 : r;
    endfunction

    // Byte counts outside the supported range are pulled to the nearest end.
    function automatic logic [2:0] frame_len(input logic [2:0] n);
        if (n < MIN_FRAME_BYTES)
            return 3'(MIN_FRAME_BYTES);
        if (n > MAX_FRAME_BYTES)
            return 3'(MAX_FRAME_BYTES);
        return n;
    endfunction

    function automatic logic [15:0] mark_span();
        return ln_bytes[ln_byte][ln_bit] ? span(cfg_one) : span(cfg_zero);
    endfunction

    // Number of tick words from a load until the tick that ends the frame.
    function automatic int frame_ticks(input logic [7:0] a, b, c, d, input logic [2:0] n);
        logic [31:0] bits;
        int          total;
        int          i;
        bits = {a, b, c, d};
        total = int'(span(cfg_ready)) + int'(span(cfg_sync)) + int'(span(cfg_delim));
        for (i = 0; i < 8 * frame_len(n); i++)
            total += int'(bits[31-i] ? span(cfg_one) : span(cfg_zero)) + int'(span(cfg_delim));
        return total;
    endfunction

    // Apply one accepted word to the line model and queue the line state it leaves.
    task automatic advance_line(input t_cmd_word w);
        t_line_sample s;
        s = '0;
        if (w.func == FUNC_LOAD) begin
            if (ln_state != LS_IDLE) begin
                // A load in the middle of a frame is dropped and flagged.
                s.rejected = 1'b1;
            end else begin
                ln_bytes[0] = w.d0;
                ln_bytes[1] = w.d1;
                ln_bytes[2] = w.d2;
                ln_bytes[3] = w.d3;
                ln_len   = frame_len(w.count);
                ln_byte  = '0;
                ln_bit   = TOP_BIT;
                ln_state = LS_READY;
                ln_timer = span(cfg_ready);
            end
        end else if (ln_state != LS_IDLE) begin
            if (ln_timer != 0)
                ln_timer--;
            if (ln_timer == 0) begin
                case (ln_state)
                    LS_READY: begin
                        ln_state = LS_SYNC_MARK;
                        ln_timer = span(cfg_sync);
                    end
                    LS_SYNC_MARK: begin
                        ln_state = LS_SYNC_GAP;
                        ln_timer = span(cfg_delim);
                    end
                    LS_SYNC_GAP: begin
                        ln_state = LS_BIT_MARK;
                        ln_timer = mark_span();
                    end
                    LS_BIT_MARK: begin
                        ln_state = LS_BIT_GAP;
                        ln_timer = span(cfg_delim);
                    end
                    default: begin
                        // End of a bit's delimiter: step to the next bit, MSB first.
                        if (ln_bit == 0) begin
                            ln_byte++;
                            ln_bit = TOP_BIT;
                        end else begin
                            ln_bit--;
                        end
                        if (ln_byte >= ln_len) begin
                            ln_state = LS_IDLE;
                            ln_timer = '0;
                            ln_byte  = '0;
                            ln_bit   = TOP_BIT;
                            s.done   = 1'b1;
                        end else begin
                            ln_state = LS_BIT_MARK;
                            ln_timer = mark_span();
                        end
                    end
                endcase
            end
        end
        s.drive = (ln_state >= LS_SYNC_MARK);
        s.level = !(ln_state == LS_SYNC_MARK || ln_state == LS_BIT_MARK);
        s.busy  = (ln_state != LS_IDLE);
        line_expect_q.push_back(s);
    endtask

    // Sender. A word is popped from cmd_q, held back for its gap, then presented
    // until it is accepted. The word on the ports is the one fed to the line model.
    t_cmd_word tx_word;
    logic      tx_busy = 1'b0;
    int        tx_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                advance_line(tx_word);
                tx_busy = 1'b0;
            end
            if (!tx_busy && cmd_q.size() != 0) begin
                tx_word = cmd_q.pop_front();
                tx_gap  = int'(tx_word.gap);
                tx_busy = 1'b1;
            end
            if (tx_busy && tx_gap == 0) begin
                i_in_valid    <= 1'b1;
                i_func        <= tx_word.func;
                i_first_byte  <= tx_word.d0;
                i_second_byte <= tx_word.d1;
                i_third_byte  <= tx_word.d2;
                i_fourth_byte <= tx_word.d3;
                i_byte_count  <= tx_word.count;
            end else begin
                i_in_valid <= 1'b0;
                if (tx_busy)
                    tx_gap--;
            end
        end
    end

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0b actual %0b", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver. Every taken result word is checked against the oldest expectation,
    // then the receiver stalls for a freshly drawn number of cycles.
    int           rx_hold = 0;
    t_line_sample rx_want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (line_expect_q.size() == 0) begin
                    $display("%0t ns: result word with nothing expected", $time);
                    mismatches++;
                end else begin
                    rx_want = line_expect_q.pop_front();
                    check_field("line_drive_enable", rx_want.drive, o_line_drive_enable);
                    check_field("line_level", rx_want.level, o_line_level);
                    check_field("busy_res", rx_want.busy, o_busy_res);
                    check_field("frame_done", rx_want.done, o_frame_done);
                    check_field("command_rejected", rx_want.rejected, o_command_rejected);
                end
                if ($urandom_range(0, 39) == 0)
                    rx_lazy = !rx_lazy;
                rx_hold = (quick_run || !rx_lazy) ? 0 : $urandom_range(0, 12);
            end else if (rx_hold != 0) begin
                rx_hold--;
            end
            i_out_stall <= (rx_hold != 0);
        end
    end

    task automatic queue_word(input logic f, input logic [7:0] a, b, c, d,
                              input logic [2:0] n);
        t_cmd_word w;
        if (!quick_run && $urandom_range(0, 39) == 0)
            tx_lazy = !tx_lazy;
        w.func  = f;
        w.d0    = a;
        w.d1    = b;
        w.d2    = c;
        w.d3    = d;
        w.count = n;
        w.gap   = (quick_run || !tx_lazy) ? 4'd0 : 4'($urandom_range(0, 12));
        cmd_q.push_back(w);
    endtask

    // A load followed by exactly the ticks that run its frame to the end. With
    // reject_odds set, stray loads land inside the frame and must be refused;
    // the first may come straight after the load. The other fields of tick
    // words carry noise, which the block has to ignore.
    task automatic queue_frame(input logic [7:0] a, b, c, d, input logic [2:0] n,
                               input int reject_odds);
        int ticks;
        int k;
        ticks = frame_ticks(a, b, c, d, n);
        queue_word(FUNC_LOAD, a, b, c, d, n);
        words_made += 1 + ticks;
        for (k = 0; k < ticks; k++) begin
            if (reject_odds != 0 && $urandom_range(1, reject_odds) == 1) begin
                queue_word(FUNC_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom), 3'($urandom_range(0, 7)));
                words_made++;
            end
            queue_word(FUNC_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 3'($urandom_range(0, 7)));
        end
    endtask

    // Wait until every word has gone in and every result has come back.
    task automatic settle();
        while (cmd_q.size() != 0 || tx_busy || line_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            REG_READY_TICKS:     cfg_ready = val;
            REG_SYNC_TICKS:      cfg_sync  = val;
            REG_ONE_TICKS:       cfg_one   = val;
            REG_ZERO_TICKS:      cfg_zero  = val;
            REG_DELIMITER_TICKS: cfg_delim = val;
            default: ;
        endcase
    endtask

    // Only called with the sequencer idle and nothing in flight.
    task automatic set_config(input logic [15:0] r, s, o, z, d);
        write_reg(REG_READY_TICKS, r);
        write_reg(REG_SYNC_TICKS, s);
        write_reg(REG_ONE_TICKS, o);
        write_reg(REG_ZERO_TICKS, z);
        write_reg(REG_DELIMITER_TICKS, d);
        i_cfg_we <= 1'b0;
    endtask

    // Short pulse lengths keep random frames to a few dozen ticks; now and then
    // one register is stretched so that some phase runs longer than the rest.
    function automatic logic [15:0] short_len();
        return ($urandom_range(0, 5) == 0) ? 16'($urandom_range(8, 30))
                                           : 16'($urandom_range(0, 3));
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // Reset pulse lengths: a tick while idle leaves the line released.
        quick_run = 1'b1;
        queue_word(FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
        settle();
        quick_run = 1'b0;

        // All registers zero, so every phase lasts one tick. Covers out-of-range
        // byte counts at both ends, all-ones and all-zeros bytes, loads while busy,
        // and a tick while idle with every other field set.
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_word(FUNC_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
        queue_frame(8'hFF, 8'h00, 8'hFF, 8'h00, 3'd0, 4);
        queue_frame(8'h00, 8'hFF, 8'h5A, 8'hA5, 3'd7, 0);
        queue_frame(8'h12, 8'h34, 8'h56, 8'h78, 3'd3, 0);
        queue_frame(8'hC3, 8'h81, 8'hFF, 8'hFF, 3'd1, 6);
        queue_frame(8'h01, 8'h80, 8'h7E, 8'hE7, 3'd4, 0);
        settle();

        // Longer ready wait, sync mark and one mark in a single frame; the other
        // registers at zero. Then a longer zero mark, on the very last bit.
        quick_run = 1'b1;
        set_config(16'd40, 16'd30, 16'd20, 16'd0, 16'd0);
        queue_frame(8'h80, 8'h00, 8'h00, 8'h00, 3'd2, 0);
        settle();
        set_config(16'd1, 16'd1, 16'd1, 16'd25, 16'd1);
        queue_frame(8'hFF, 8'hFE, 8'h00, 8'h00, 3'd2, 0);
        settle();
        quick_run = 1'b0;

        // Random phases: mostly complete frames with random content, with stray
        // loads inside frames and idle ticks between them.
        repeat (3) begin
            set_config(short_len(), short_len(), short_len(), short_len(), short_len());
            words_made = 0;
            while (words_made < PHASE_WORDS) begin
                queue_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            3'($urandom_range(0, 7)), 10);
                repeat ($urandom_range(0, 3))
                    queue_word(FUNC_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom), 3'($urandom_range(0, 7)));
            end
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (line_expect_q.size() != 0) begin
            $display("%0t ns: %0d result words never arrived", $time, line_expect_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
